// ===== rtl/v3n_pkg.sv =====
// ----------------------------------------------------------------------------
// v3n_pkg: shared types for the vector normaliser
// Word types for the request and response channels.
// ----------------------------------------------------------------------------
package v3n_pkg;

   localparam int InWidth      = 16;
   localparam int UnitFracBits = 14;
   localparam int UnitWidth    = UnitFracBits + 2;

   typedef struct packed {
      logic signed [InWidth-1:0] vec_x;
      logic signed [InWidth-1:0] vec_y;
      logic signed [InWidth-1:0] vec_z;
   } req_word_type;

   typedef struct packed {
      logic [InWidth-1:0]          magnitude;
      logic signed [UnitWidth-1:0] unit_x;
      logic signed [UnitWidth-1:0] unit_y;
      logic signed [UnitWidth-1:0] unit_z;
      logic                        zero_vector;
   } rsp_word_type;

endpackage

// ===== rtl/v3n_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// v3n_sqrt_cell: one step of the digit-by-digit square root
// Retires one result bit per cycle and passes the partial state onwards.
// ----------------------------------------------------------------------------
module v3n_sqrt_cell
   import v3n_pkg::*;
#(
   parameter int SW = 34,
   parameter int RW = 17,
   parameter int STEP = 0,
   parameter int AW = 16
) (
   input  logic           clock,
   input  logic [SW-1:0]  rem_i,
   input  logic [RW-1:0]  root_i,
   input  logic [AW-1:0]  ax_i, ay_i, az_i,
   input  logic           nx_i, ny_i, nz_i,
   input  logic           v_i,
   output logic [SW-1:0]  rem_o,
   output logic [RW-1:0]  root_o,
   output logic [AW-1:0]  ax_o, ay_o, az_o,
   output logic           nx_o, ny_o, nz_o,
   output logic           v_o
);
   localparam int BP = 2 * (RW - 1 - STEP);

   logic [SW+1:0] trial;
   logic [SW-1:0] rem_in;
   logic [RW-1:0] root_in;

   // Trial subtract of (2*root*2^k + 4^k) at this bit position.
   always_comb begin
      trial   = ({2'b0, rem_i}) - ((SW+2)'(root_i) << (BP/2 + 1))
                - ((SW+2)'(1) << BP);
      rem_in  = rem_i;
      root_in = root_i;
      if (!trial[SW+1]) begin
         rem_in  = trial[SW-1:0];
         root_in = root_i | (RW'(1) << (RW - 1 - STEP));
      end
   end

   always_ff @(posedge clock) begin
      rem_o  <= rem_in;
      root_o <= root_in;
      ax_o   <= ax_i;  ay_o <= ay_i;  az_o <= az_i;
      nx_o   <= nx_i;  ny_o <= ny_i;  nz_o <= nz_i;
      v_o    <= v_i;
   end
endmodule

// ===== rtl/v3n_div_cell.sv =====
// ----------------------------------------------------------------------------
// v3n_div_cell: one restoring division step for the three components
// Each cell retires one quotient bit for x, y and z at once.
// ----------------------------------------------------------------------------
module v3n_div_cell
   import v3n_pkg::*;
#(
   parameter int DW = 34,
   parameter int QW = 17,
   parameter int STEP = 0
) (
   input  logic               clock,
   input  logic [DW-1:0]      den_i,
   input  logic [3*DW-1:0]    rem_i,
   input  logic [3*QW-1:0]    quo_i,
   input  logic [2:0]         neg_i,
   input  logic               zero_i,
   input  logic [InWidth-1:0] mag_i,
   input  logic               v_i,
   output logic [DW-1:0]      den_o,
   output logic [3*DW-1:0]    rem_o,
   output logic [3*QW-1:0]    quo_o,
   output logic [2:0]         neg_o,
   output logic               zero_o,
   output logic [InWidth-1:0] mag_o,
   output logic               v_o
);
   localparam int SH = QW - 1 - STEP;

   logic [3*DW-1:0] rem_in;
   logic [3*QW-1:0] quo_in;
   logic [DW+QW-1:0] sub;
   logic [DW+QW-1:0] dsh;

   // Compare each remainder against the shifted denominator.
   always_comb begin
      rem_in = rem_i;
      quo_in = quo_i;
      dsh    = (DW+QW)'(den_i) << SH;
      sub    = '0;
      for (int k = 0; k < 3; k++) begin
         sub = (DW+QW)'(rem_i[k*DW +: DW]);
         if (sub >= dsh) begin
            sub = sub - dsh;
            rem_in[k*DW +: DW]   = sub[DW-1:0];
            quo_in[k*QW + SH]    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      den_o  <= den_i;  rem_o <= rem_in;  quo_o <= quo_in;
      neg_o  <= neg_i;  zero_o <= zero_i; mag_o <= mag_i;
      v_o    <= v_i;
   end
endmodule

// ===== rtl/vector3_normalize.sv =====
// Stages from the edge that takes start to the edge that takes the response:
// 1 input, 1 squares, 17 root cells, 1 round, 16 divider cells.
// Throughput: one word per cycle; busy is always low, as each row of cells holds
// one word per stage.
// Reset clears the valid bits of every stage; no word is lost or invented.
// ----------------------------------------------------------------------------
// vector3_normalize: magnitude and unit vector of a 3D vector
// Square root by a row of digit cells, then a row of division cells.
// ----------------------------------------------------------------------------
module vector3_normalize
   import v3n_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);
   localparam int AW = InWidth;
   localparam int SW = 2 * InWidth + 2;
   localparam int RW = InWidth + 1;
   localparam int DW = AW + UnitFracBits + 2;
   localparam int QW = UnitWidth;

   logic [AW-1:0] ax_in, ay_in, az_in;
   logic [AW-1:0] ax_ff, ay_ff, az_ff;
   logic [SW-1:0] sum_ff;
   logic          nx_ff, ny_ff, nz_ff, v_ff;
   logic [2*AW-1:0] px, py, pz;

   assign busy = 1'b0;

   // Absolute values of the three components.
   always_comb begin
      ax_in = req_word.vec_x[AW-1] ? AW'(-req_word.vec_x) : AW'(req_word.vec_x);
      ay_in = req_word.vec_y[AW-1] ? AW'(-req_word.vec_y) : AW'(req_word.vec_y);
      az_in = req_word.vec_z[AW-1] ? AW'(-req_word.vec_z) : AW'(req_word.vec_z);
   end

   assign px = ax_ff * ax_ff;
   assign py = ay_ff * ay_ff;
   assign pz = az_ff * az_ff;

   // Input register stage.
   always_ff @(posedge clock) begin
      ax_ff <= ax_in;  ay_ff <= ay_in;  az_ff <= az_in;
      nx_ff <= req_word.vec_x[AW-1];
      ny_ff <= req_word.vec_y[AW-1];
      nz_ff <= req_word.vec_z[AW-1];
      if (reset) v_ff <= 1'b0;
      else       v_ff <= start;
   end

   // Squares stage.
   logic [SW-1:0] s_rem [RW+1];
   logic [RW-1:0] s_root [RW+1];
   logic [AW-1:0] s_ax [RW+1], s_ay [RW+1], s_az [RW+1];
   logic          s_nx [RW+1], s_ny [RW+1], s_nz [RW+1], s_v [RW+1];

   always_ff @(posedge clock) begin
      sum_ff <= SW'(px) + SW'(py) + SW'(pz);
   end
   logic [AW-1:0] ax2_ff, ay2_ff, az2_ff;
   logic nx2_ff, ny2_ff, nz2_ff, v2_ff;
   always_ff @(posedge clock) begin
      ax2_ff <= ax_ff; ay2_ff <= ay_ff; az2_ff <= az_ff;
      nx2_ff <= nx_ff; ny2_ff <= ny_ff; nz2_ff <= nz_ff;
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v_ff;
   end

   assign s_rem[0] = sum_ff;  assign s_root[0] = '0;
   assign s_ax[0] = ax2_ff;   assign s_ay[0] = ay2_ff;  assign s_az[0] = az2_ff;
   assign s_nx[0] = nx2_ff;   assign s_ny[0] = ny2_ff;  assign s_nz[0] = nz2_ff;
   assign s_v[0]  = v2_ff;

   // Row of square-root cells.
   for (genvar g = 0; g < RW; g++) begin : g_sqrt
      logic v_raw;
      v3n_sqrt_cell #(.SW(SW), .RW(RW), .STEP(g), .AW(AW)) u_cell (
         .clock(clock), .rem_i(s_rem[g]), .root_i(s_root[g]),
         .ax_i(s_ax[g]), .ay_i(s_ay[g]), .az_i(s_az[g]),
         .nx_i(s_nx[g]), .ny_i(s_ny[g]), .nz_i(s_nz[g]), .v_i(s_v[g] & !reset),
         .rem_o(s_rem[g+1]), .root_o(s_root[g+1]),
         .ax_o(s_ax[g+1]), .ay_o(s_ay[g+1]), .az_o(s_az[g+1]),
         .nx_o(s_nx[g+1]), .ny_o(s_ny[g+1]), .nz_o(s_nz[g+1]), .v_o(v_raw));
      assign s_v[g+1] = v_raw;
   end

   // Rounding stage: remainder above root means round up.
   logic [RW-1:0] mag_in;
   logic [AW-1:0] mag_ff;
   logic [AW-1:0] rax_ff, ray_ff, raz_ff;
   logic [2:0]    rneg_ff;
   logic          rzero_ff, rv_ff;
   assign mag_in = (s_rem[RW] > SW'(s_root[RW])) ? s_root[RW] + RW'(1) : s_root[RW];
   always_ff @(posedge clock) begin
      mag_ff   <= mag_in[AW-1:0];
      rax_ff   <= s_ax[RW]; ray_ff <= s_ay[RW]; raz_ff <= s_az[RW];
      rneg_ff  <= {s_nz[RW], s_ny[RW], s_nx[RW]};
      rzero_ff <= (s_root[RW] == '0) && (s_rem[RW] == '0);
      if (reset) rv_ff <= 1'b0;
      else       rv_ff <= s_v[RW];
   end

   // Division cells: q = (2a*2^F + m) / (2m).
   logic [DW-1:0]   d_den [QW+1];
   logic [3*DW-1:0] d_rem [QW+1];
   logic [3*QW-1:0] d_quo [QW+1];
   logic [2:0]      d_neg [QW+1];
   logic            d_zero [QW+1];
   logic [AW-1:0]   d_mag [QW+1];
   logic            d_v [QW+1];

   assign d_den[0] = DW'(mag_ff) << 1;
   assign d_rem[0] = {DW'((DW'(raz_ff) << (UnitFracBits + 1)) + DW'(mag_ff)),
                      DW'((DW'(ray_ff) << (UnitFracBits + 1)) + DW'(mag_ff)),
                      DW'((DW'(rax_ff) << (UnitFracBits + 1)) + DW'(mag_ff))};
   assign d_quo[0]  = '0;
   assign d_neg[0]  = rneg_ff;
   assign d_zero[0] = rzero_ff;
   assign d_mag[0]  = mag_ff;
   assign d_v[0]    = rv_ff;

   for (genvar g = 0; g < QW; g++) begin : g_div
      logic v_raw;
      v3n_div_cell #(.DW(DW), .QW(QW), .STEP(g)) u_cell (
         .clock(clock), .den_i(d_den[g]), .rem_i(d_rem[g]), .quo_i(d_quo[g]),
         .neg_i(d_neg[g]), .zero_i(d_zero[g]), .mag_i(d_mag[g]), .v_i(d_v[g] & !reset),
         .den_o(d_den[g+1]), .rem_o(d_rem[g+1]), .quo_o(d_quo[g+1]),
         .neg_o(d_neg[g+1]), .zero_o(d_zero[g+1]), .mag_o(d_mag[g+1]), .v_o(v_raw));
      assign d_v[g+1] = v_raw;
   end

   // Output word: apply signs, force zero for the zero vector.
   always_comb begin
      rsp_valid            = d_v[QW];
      rsp_word.magnitude   = d_mag[QW];
      rsp_word.zero_vector = d_zero[QW];
      rsp_word.unit_x = d_zero[QW] ? '0 : UnitWidth'(d_neg[QW][0] ? -d_quo[QW][0*QW +: QW]
                                                                 :  d_quo[QW][0*QW +: QW]);
      rsp_word.unit_y = d_zero[QW] ? '0 : UnitWidth'(d_neg[QW][1] ? -d_quo[QW][1*QW +: QW]
                                                                 :  d_quo[QW][1*QW +: QW]);
      rsp_word.unit_z = d_zero[QW] ? '0 : UnitWidth'(d_neg[QW][2] ? -d_quo[QW][2*QW +: QW]
                                                                 :  d_quo[QW][2*QW +: QW]);
   end

   // A zero vector always reports zero magnitude.
   a_zero_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.zero_vector |-> rsp_word.magnitude == '0)
      else $error("zero vector with non-zero magnitude");
   // The interface never stalls.
   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");
   // A valid word leaving the root row enters the rounding stage in the next cycle.
   a_round_valid: assert property (@(posedge clock) disable iff (reset)
      s_v[RW] |=> rv_ff)
      else $error("word lost at rounding stage");
endmodule
